// ===== hw/rtl/dtpt_pkg.sv =====
`timescale 1ns / 1ps

package dtpt_pkg;

   // Fixed field widths
   localparam int RADIUS_W   = 23;
   localparam int COUNT_W    = 11;
   localparam int PASS_W     = 8;
   localparam int SHRINK_W   = 16;
   localparam int INDEX_W    = 20;
   localparam int CSR_DATA_W = 23;
   localparam int CSR_IDX_W  = 2;
   localparam int R2_W       = 2 * RADIUS_W;

   // Result word layout
   localparam int RSP_TDATA_W = ((INDEX_W + COUNT_W + 7) / 8) * 8;
   localparam int RSP_TUSER_W = 2;
   localparam int RSP_HELD_LO = INDEX_W;
   localparam int RSP_HELD_HI = INDEX_W + COUNT_W - 1;
   localparam int RSP_ACC_BIT = 0;
   localparam int RSP_FIN_BIT = 1;

   // Register reset values
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1024);
   localparam logic [COUNT_W-1:0]  TARGET_RESET = COUNT_W'(1024);
   localparam logic [PASS_W-1:0]   PASSES_RESET = PASS_W'(100);
   localparam logic [SHRINK_W-1:0] SHRINK_RESET = SHRINK_W'(58982);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INITIAL_RADIUS = 2'd0,
      CSR_TARGET_COUNT   = 2'd1,
      CSR_MAX_PASSES     = 2'd2,
      CSR_SHRINK_FACTOR  = 2'd3
   } dtpt_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } dtpt_state_type;

   // Status of the distance pipeline toward the sequencer
   typedef struct packed {
      logic busy;
      logic hit;
   } dtpt_dist_status_type;

endpackage

// ===== hw/rtl/dtpt_ram.sv =====
`timescale 1ns / 1ps

module dtpt_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/dtpt_dist.sv =====
`timescale 1ns / 1ps

module dtpt_dist
   import dtpt_pkg::*;
#(
   parameter int COORD_WIDTH = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       issue,
   input  logic [3*COORD_WIDTH-1:0]   point,
   input  logic [3*COORD_WIDTH-1:0]   sample,
   input  logic [R2_W-1:0]            r2,
   output dtpt_dist_status_type       status
);

   localparam int DW    = COORD_WIDTH + 1;
   localparam int SQ_W  = 2 * DW;
   localparam int SUM_W = SQ_W + 2;
   localparam int CMP_W = (SUM_W > R2_W) ? SUM_W : R2_W;

   logic              v0_ff, v1_ff, v2_ff, v3_ff;
   logic              hit_ff, hit_in;
   logic [DW-1:0]     mag_ff [3];
   logic [DW-1:0]     mag_in [3];
   logic [SQ_W-1:0]   sq_ff  [3];
   logic [SUM_W-1:0]  sum;

   // Stage 1: absolute coordinate differences against the sample just read
   always_comb begin
      logic signed [DW-1:0] diff;
      for (int a = 0; a < 3; a++) begin
         diff = $signed({point[a*COORD_WIDTH + COORD_WIDTH-1],
                         point[a*COORD_WIDTH +: COORD_WIDTH]})
              - $signed({sample[a*COORD_WIDTH + COORD_WIDTH-1],
                         sample[a*COORD_WIDTH +: COORD_WIDTH]});
         mag_in[a] = diff[DW-1] ? DW'(-diff) : DW'(diff);
      end
   end

   // Stage 3: sum of squares against radius squared
   assign sum    = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
   assign hit_in = v2_ff && (CMP_W'(sum) <= CMP_W'(r2));

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff  <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         v0_ff  <= issue;
         v1_ff  <= v0_ff;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         mag_ff[a] <= mag_in[a];
         sq_ff[a]  <= SQ_W'(mag_ff[a]) * SQ_W'(mag_ff[a]);
      end
   end

   assign status.busy = v0_ff | v1_ff | v2_ff | v3_ff;
   assign status.hit  = hit_ff;

endmodule

// ===== hw/rtl/dart_throwing_point_thinning.sv =====
`timescale 1ns / 1ps
// Order: a point is checked by reading the N stored samples through the distance pipeline,
//   which then drains, and an update step raises rsp_tvalid; a hit ends the reads early.
// Flow: one point at a time, N up to the store depth; the next word is taken back in idle,
//   the sample RAM has one read port, and a stalled rsp_tready holds the update step.
// Reset (synchronous, active high) restores the register defaults, empties the store
//   count, loads the default radius and clears pass count, done and both channels.

module dart_throwing_point_thinning
   import dtpt_pkg::*;
#(
   parameter int SAMPLE_DEPTH = 1024,
   parameter int COORD_WIDTH  = 24,
   localparam int IN_BITS     = 3 * COORD_WIDTH + INDEX_W,
   localparam int REQ_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
   input  logic                    clock,
   input  logic                    reset,
   // fields, low bit up: coord_x, coord_y, coord_z, point_index, zero fill
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   input  logic                    req_tlast,   // last_of_pass
   input  logic                    req_tuser,   // first_of_cloud
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // fields, low bit up: result_index, samples_held, zero fill
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   // fields, low bit up: accepted, finished
   output logic [RSP_TUSER_W-1:0]  rsp_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic                    csr_wen,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CW     = COORD_WIDTH;
   localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
   localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
   localparam int TC_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int PROD_W = RADIUS_W + SHRINK_W;

   // Configuration registers
   logic [RADIUS_W-1:0] init_radius_ff, init_radius_in;
   logic [COUNT_W-1:0]  target_ff, target_in;
   logic [PASS_W-1:0]   max_pass_ff, max_pass_in;
   logic [SHRINK_W-1:0] shrink_ff, shrink_in;

   // Sequencer and run state
   dtpt_state_type      state_ff, state_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [PASS_W-1:0]   pass_ff, pass_in;
   logic                done_ff, done_in;
   logic                hit_ff, hit_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [R2_W-1:0]     r2_ff;

   // Point under test
   logic [3*CW-1:0]     point_ff, point_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic                last_ff, last_in;

   // Result word register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic                rsp_acc_ff, rsp_acc_in;
   logic                rsp_fin_ff, rsp_fin_in;
   logic [COUNT_W-1:0]  rsp_held_ff, rsp_held_in;

   logic                req_fire;
   logic                rsp_free;
   logic                issue;
   logic                ram_wen;
   logic [3*CW-1:0]     sample;
   logic [PROD_W-1:0]   shrunk;
   dtpt_dist_status_type dist_status;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   // a result may leave the datapath once the output slot is empty or draining
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   // issue one stored sample per cycle until the store is exhausted, a hit is seen or the run is done
   assign issue      = (state_ff == ST_SCAN) && !done_ff && !hit_ff && (cnt_ff != total_ff);
   assign shrunk     = PROD_W'(radius_ff) * PROD_W'(shrink_ff);

   // Configuration writes
   always_comb begin
      init_radius_in = init_radius_ff;
      target_in      = target_ff;
      max_pass_in    = max_pass_ff;
      shrink_in      = shrink_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_INITIAL_RADIUS: init_radius_in = csr_wdata[RADIUS_W-1:0];
            CSR_TARGET_COUNT:   target_in      = csr_wdata[COUNT_W-1:0];
            CSR_MAX_PASSES:     max_pass_in    = csr_wdata[PASS_W-1:0];
            CSR_SHRINK_FACTOR:  shrink_in      = csr_wdata[SHRINK_W-1:0];
         endcase
      end
   end

   // Sequencer: take a point, scan the store, then update counters and post the result
   always_comb begin
      logic [CNT_W-1:0]  t_first;
      logic [CNT_W-1:0]  t_plus;
      logic              d_first;
      logic              acc;
      logic              d_acc;
      logic [PASS_W-1:0] p_plus;

      state_in     = state_ff;
      total_in     = total_ff;
      radius_in    = radius_ff;
      pass_in      = pass_ff;
      done_in      = done_ff;
      hit_in       = hit_ff | dist_status.hit;
      cnt_in       = cnt_ff;
      point_in     = point_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_index_in = rsp_index_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_held_in  = rsp_held_ff;
      ram_wen      = 1'b0;

      t_first = req_tuser ? '0 : total_ff;
      d_first = req_tuser ? 1'b0 : done_ff;
      t_plus  = CNT_W'(total_ff + 1'b1);
      acc     = !done_ff && !hit_ff;
      d_acc   = done_ff || (acc && ((TC_W'(t_plus) >= TC_W'(target_ff))
                                 || (TC_W'(t_plus) >= TC_W'(SAMPLE_DEPTH))));
      p_plus  = PASS_W'(pass_ff + 1'b1);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // start of cloud: empty the store and reload the radius
               total_in  = t_first;
               pass_in   = req_tuser ? '0 : pass_ff;
               radius_in = req_tuser ? init_radius_ff : radius_ff;
               done_in   = d_first || (TC_W'(t_first) >= TC_W'(target_ff))
                                   || (TC_W'(t_first) >= TC_W'(SAMPLE_DEPTH));
               hit_in    = 1'b0;
               cnt_in    = '0;
               point_in  = req_tdata[3*CW-1:0];
               idx_in    = req_tdata[3*CW +: INDEX_W];
               last_in   = req_tlast;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               cnt_in = CNT_W'(cnt_ff + 1'b1);
            end else if (!dist_status.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               ram_wen = acc;
               total_in = acc ? t_plus : total_ff;
               done_in  = d_acc;
               if (last_ff && !d_acc) begin
                  pass_in = p_plus;
                  if (p_plus >= max_pass_ff) begin
                     done_in = 1'b1;
                  end else begin
                     radius_in = shrunk[PROD_W-1:SHRINK_W];
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_index_in = idx_ff;
               rsp_acc_in   = acc;
               rsp_fin_in   = done_in;
               rsp_held_in  = COUNT_W'(total_in);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_radius_ff <= RADIUS_RESET;
         target_ff      <= TARGET_RESET;
         max_pass_ff    <= PASSES_RESET;
         shrink_ff      <= SHRINK_RESET;
         state_ff       <= ST_IDLE;
         total_ff       <= '0;
         radius_ff      <= RADIUS_RESET;
         pass_ff        <= '0;
         done_ff        <= 1'b0;
         hit_ff         <= 1'b0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         init_radius_ff <= init_radius_in;
         target_ff      <= target_in;
         max_pass_ff    <= max_pass_in;
         shrink_ff      <= shrink_in;
         state_ff       <= state_in;
         total_ff       <= total_in;
         radius_ff      <= radius_in;
         pass_ff        <= pass_in;
         done_ff        <= done_in;
         hit_ff         <= hit_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload: no reset needed
   always_ff @(posedge clock) begin
      point_ff     <= point_in;
      idx_ff       <= idx_in;
      last_ff      <= last_in;
      rsp_index_ff <= rsp_index_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_fin_ff   <= rsp_fin_in;
      rsp_held_ff  <= rsp_held_in;
      // radius squared settles well before the first compare of a scan
      r2_ff        <= R2_W'(radius_ff) * R2_W'(radius_ff);
   end

   // Sample store: x, y, z packed in one word, written at the fill position on accept.
   // Writes land in the update cycle, so no scan ever overlaps a write.
   dtpt_ram #(
      .WIDTH (3 * CW),
      .DEPTH (SAMPLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wen),
      .wr_addr (total_ff[ADDR_W-1:0]),
      .wr_data (point_ff),
      .rd_en   (issue),
      .rd_addr (cnt_ff[ADDR_W-1:0]),
      .rd_data (sample)
   );

   dtpt_dist #(
      .COORD_WIDTH (CW)
   ) u_dist (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .point  (point_ff),
      .sample (sample),
      .r2     (r2_ff),
      .status (dist_status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_held_ff, rsp_index_ff});
   assign rsp_tuser  = {rsp_fin_ff, rsp_acc_ff};

endmodule

// ===== hw/rtl/dtpt_checker.sv =====
`timescale 1ns / 1ps

module dtpt_checker
   import dtpt_pkg::*;
#(
   parameter int SAMPLE_DEPTH = 1024
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic [RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [RSP_TUSER_W-1:0]  rsp_tuser,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready
);

   // the count stops at the store depth or at the largest target, whichever is lower
   localparam int TARGET_MAX = (2 ** COUNT_W) - 1;
   localparam int HELD_CAP   = (SAMPLE_DEPTH < TARGET_MAX) ? SAMPLE_DEPTH : TARGET_MAX;

   logic       req_fire, rsp_fire;
   logic [1:0] open_ff;
   logic [COUNT_W-1:0] held;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign held     = rsp_tdata[RSP_HELD_HI:RSP_HELD_LO];

   // points taken minus results delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 2'd0;
      end else begin
         open_ff <= 2'(open_ff + {1'b0, req_fire} - {1'b0, rsp_fire});
      end
   end

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("next point taken while one is still being judged");

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      (open_ff <= 2'd2) && (!rsp_tvalid || open_ff != 2'd0))
      else $error("result count does not track point count");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (held <= COUNT_W'(HELD_CAP))
                  && (!rsp_tuser[RSP_ACC_BIT] || held != '0))
      else $error("sample count out of range for result");

endmodule

bind dart_throwing_point_thinning dtpt_checker #(
   .SAMPLE_DEPTH (SAMPLE_DEPTH)
) u_dtpt_checker (.*);

// ===== tb/dart_throwing_point_thinning_test.sv =====
`timescale 1ns / 1ps

module dart_throwing_point_thinning_test;
   import dtpt_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int COORD_W     = 24;
   localparam int IN_BITS     = 3 * COORD_W + INDEX_W;
   localparam int REQ_TDATA_W = ((IN_BITS + 7) / 8) * 8;
   localparam int PRINT_LIMIT = 40;

   // One point of the cloud as it travels on the request side
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [INDEX_W-1:0]        index;
      logic                      last_of_pass;
      logic                      first_of_cloud;
   } point_type;

   // The verdict the block returns for one point
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               accepted;
      logic               finished;
      logic [COUNT_W-1:0] held;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // fields, low bit up: coord_x, coord_y, coord_z, point_index, zero fill
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tlast = 1'b0;   // last_of_pass
   logic                   req_tuser = 1'b0;   // first_of_cloud
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // fields, low bit up: result_index, samples_held, zero fill
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // fields, low bit up: accepted, finished
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_INITIAL_RADIUS;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   dart_throwing_point_thinning #(
      .SAMPLE_DEPTH(STORE_DEPTH),
      .COORD_WIDTH (COORD_W)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tuser (req_tuser),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow of the thinning state: registers, sample store, counters.
   // Starts at the reset values of the block.
   // ---------------------------------------------------------------------
   logic [RADIUS_W-1:0] cfg_initial_radius = RADIUS_RESET;
   logic [COUNT_W-1:0]  cfg_target_count   = TARGET_RESET;
   logic [PASS_W-1:0]   cfg_max_passes     = PASSES_RESET;
   logic [SHRINK_W-1:0] cfg_shrink         = SHRINK_RESET;

   logic signed [COORD_W-1:0] sample_x [STORE_DEPTH];
   logic signed [COORD_W-1:0] sample_y [STORE_DEPTH];
   logic signed [COORD_W-1:0] sample_z [STORE_DEPTH];
   int                  samples_stored = 0;
   logic [RADIUS_W-1:0] radius_now     = RADIUS_RESET;
   logic [PASS_W-1:0]   passes_done    = '0;
   logic                thinning_done  = 1'b0;

   point_type   pending_points[$];    // words waiting for the driver
   verdict_type expected_verdicts[$]; // verdicts owed by the block, oldest first

   int   points_outstanding = 0;   // queued but not yet answered
   int   error_count        = 0;
   int   results_checked    = 0;
   int   samples_taken      = 0;
   int   settings_used      = 0;
   int   random_items       = 0;

   // driver and monitor bookkeeping
   point_type req_point_now;
   bit     req_word_taken = 1'b0;
   int     req_gap_left   = 0;
   int     req_calm_left  = 0;
   int     rsp_stall_left = 0;
   int     rsp_calm_left  = 0;

   // Squared distance check against every stored sample, then pass-end bookkeeping.
   function automatic verdict_type judge_point(point_type p);
      verdict_type v;
      longint   r2;
      longint   dx;
      longint   dy;
      longint   dz;
      bit       hit;
      int       k;
      if (p.first_of_cloud) begin
         samples_stored = 0;
         radius_now     = cfg_initial_radius;
         passes_done    = '0;
         thinning_done  = 1'b0;
      end
      if (samples_stored >= int'(cfg_target_count) || samples_stored >= STORE_DEPTH)
         thinning_done = 1'b1;
      v.accepted = 1'b0;
      if (!thinning_done && samples_stored < STORE_DEPTH) begin
         r2  = longint'(radius_now) * longint'(radius_now);
         hit = 1'b0;
         for (k = 0; k < samples_stored && !hit; k++) begin
            dx = longint'(p.x) - longint'(sample_x[k]);
            dy = longint'(p.y) - longint'(sample_y[k]);
            dz = longint'(p.z) - longint'(sample_z[k]);
            if (dx * dx + dy * dy + dz * dz <= r2)
               hit = 1'b1;
         end
         if (!hit) begin
            sample_x[samples_stored] = p.x;
            sample_y[samples_stored] = p.y;
            sample_z[samples_stored] = p.z;
            samples_stored++;
            v.accepted = 1'b1;
            if (samples_stored >= int'(cfg_target_count) || samples_stored >= STORE_DEPTH)
               thinning_done = 1'b1;
         end
      end
      // pass end: count it, and shrink the radius unless that made us done
      if (p.last_of_pass && !thinning_done) begin
         passes_done = passes_done + 1'b1;
         if (passes_done >= cfg_max_passes)
            thinning_done = 1'b1;
         else
            radius_now = RADIUS_W'((longint'(radius_now) * longint'(cfg_shrink)) >>> 16);
      end
      v.index    = p.index;
      v.finished = thinning_done;
      v.held     = COUNT_W'(samples_stored);
      return v;
   endfunction

   // Mostly short gaps, some long ones, and now and then a calm stretch with none.
   function automatic int draw_gap(inout int calm_left);
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   task automatic add_point(int x, int y, int z, int index, bit last_of_pass,
                            bit first_of_cloud);
      point_type p;
      p.x              = COORD_W'(x);
      p.y              = COORD_W'(y);
      p.z              = COORD_W'(z);
      p.index          = INDEX_W'(index);
      p.last_of_pass   = last_of_pass;
      p.first_of_cloud = first_of_cloud;
      pending_points = {pending_points, p};
      points_outstanding++;
   endtask

   // Write all four registers back to back; only called while the block is idle.
   task automatic apply_settings(int unsigned radius, int unsigned target,
                                 int unsigned passes, int unsigned shrink);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= CSR_INITIAL_RADIUS;
      csr_wdata <= CSR_DATA_W'(RADIUS_W'(radius));
      @(negedge clock);
      csr_index <= CSR_TARGET_COUNT;
      csr_wdata <= CSR_DATA_W'(COUNT_W'(target));
      @(negedge clock);
      csr_index <= CSR_MAX_PASSES;
      csr_wdata <= CSR_DATA_W'(PASS_W'(passes));
      @(negedge clock);
      csr_index <= CSR_SHRINK_FACTOR;
      csr_wdata <= CSR_DATA_W'(SHRINK_W'(shrink));
      @(negedge clock);
      csr_wen <= 1'b0;
      cfg_initial_radius = RADIUS_W'(radius);
      cfg_target_count   = COUNT_W'(target);
      cfg_max_passes     = PASS_W'(passes);
      cfg_shrink         = SHRINK_W'(shrink);
      settings_used++;
      @(posedge clock);
   endtask

   // Hold until every queued point has its verdict, then let the pipeline drain.
   task automatic settle();
      do @(negedge clock); while (points_outstanding != 0);
      repeat (40) @(negedge clock);
      @(posedge clock);
   endtask

   // One random cloud: pick settings, build a cluster around the radius scale, and
   // stream it for several passes, salted with stray points and broken framing.
   task automatic throw_random_cloud();
      int unsigned radius;
      int unsigned target;
      int unsigned passes;
      int unsigned shrink;
      longint      half;
      longint      lim;
      longint      cx;
      longint      cy;
      longint      cz;
      int          cloud_size;
      int          rounds;
      int          r;
      int          k;
      int          roll;
      bit          skip_first;
      bit          last_flag;
      int          px [16];
      int          py [16];
      int          pz [16];

      roll = $urandom_range(0, 9);
      if (roll == 0)      radius = 0;
      else if (roll == 1) radius = 23'h7F_FFFF;
      else if (roll == 2) radius = $urandom_range(0, 23'h7F_FFFF);
      else                radius = $urandom_range(1, 1 << $urandom_range(2, 20));
      roll = $urandom_range(0, 99);
      if (roll < 10)      target = 1;
      else if (roll < 18) target = 1024;
      else                target = $urandom_range(1, 40);
      roll = $urandom_range(0, 99);
      if (roll < 10)      passes = 1;
      else if (roll < 16) passes = 255;
      else                passes = $urandom_range(1, 6);
      roll = $urandom_range(0, 99);
      if (roll < 10)      shrink = 0;
      else if (roll < 20) shrink = 16'hFFFF;
      else if (roll < 60) shrink = 58982;
      else                shrink = $urandom_range(0, 16'hFFFF);
      apply_settings(radius, target, passes, shrink);

      half = longint'(radius) * longint'($urandom_range(1, 4)) + 1;
      if (half > 8388607) half = 8388607;
      lim = 8388607 - half;
      cx  = longint'($urandom_range(0, int'(2 * lim))) - lim;
      cy  = longint'($urandom_range(0, int'(2 * lim))) - lim;
      cz  = longint'($urandom_range(0, int'(2 * lim))) - lim;
      cloud_size = $urandom_range(3, 16);
      for (k = 0; k < cloud_size; k++) begin
         px[k] = int'(cx + longint'($urandom_range(0, int'(2 * half))) - half);
         py[k] = int'(cy + longint'($urandom_range(0, int'(2 * half))) - half);
         pz[k] = int'(cz + longint'($urandom_range(0, int'(2 * half))) - half);
      end

      skip_first = ($urandom_range(0, 5) == 0);
      rounds     = $urandom_range(1, 8);
      for (r = 0; r < rounds; r++) begin
         for (k = 0; k < cloud_size; k++) begin
            roll = $urandom_range(0, 99);
            // stray point anywhere in the coordinate space, random framing
            if (roll < 8) begin
               add_point($urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
               random_items++;
            end
            last_flag = (k == cloud_size - 1);
            if ($urandom_range(0, 99) < 4) last_flag = !last_flag;
            add_point(px[k], py[k], pz[k], k, last_flag, r == 0 && k == 0 && !skip_first);
            random_items++;
         end
      end
      settle();
   endtask

   // ---------------------------------------------------------------------
   // Request driver: change at the falling edge, advance on a taken word.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_word_taken) begin
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_points.size() != 0) begin
            req_point_now = pending_points.pop_front();
            req_tdata  <= {{(REQ_TDATA_W - IN_BITS){1'b0}}, req_point_now.index,
                           req_point_now.z, req_point_now.y, req_point_now.x};
            req_tlast  <= req_point_now.last_of_pass;
            req_tuser  <= req_point_now.first_of_cloud;
            req_tvalid <= 1'b1;
            req_gap_left = draw_gap(req_calm_left);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result-side backpressure: random stalls, also at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall_left = draw_gap(rsp_calm_left);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: sample both handshakes at the rising edge. Check the returned
   // verdict against the oldest expectation, then predict the taken point.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         req_word_taken = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("verdict for point %0d with none expected",
                                         rsp_tdata[INDEX_W-1:0]));
            end else begin
               want = expected_verdicts.pop_front();
               points_outstanding--;
               results_checked++;
               samples_taken += want.accepted;
               if (rsp_tdata[INDEX_W-1:0] !== want.index)
                  report_mismatch($sformatf("result_index %0d, want %0d",
                                            rsp_tdata[INDEX_W-1:0], want.index));
               if (rsp_tuser[RSP_ACC_BIT] !== want.accepted)
                  report_mismatch($sformatf("point %0d: accepted %b, want %b",
                                            want.index, rsp_tuser[RSP_ACC_BIT],
                                            want.accepted));
               if (rsp_tuser[RSP_FIN_BIT] !== want.finished)
                  report_mismatch($sformatf("point %0d: finished %b, want %b",
                                            want.index, rsp_tuser[RSP_FIN_BIT],
                                            want.finished));
               if (rsp_tdata[RSP_HELD_HI:RSP_HELD_LO] !== want.held)
                  report_mismatch($sformatf("point %0d: samples_held %0d, want %0d",
                                            want.index, rsp_tdata[RSP_HELD_HI:RSP_HELD_LO],
                                            want.held));
            end
         end
         req_word_taken = req_tvalid && req_tready;
         if (req_word_taken)
            expected_verdicts = {expected_verdicts, judge_point(req_point_now)};
      end
   end

   // Hard stop if the block hangs.
   initial begin
      #(100_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus sequence
   // ---------------------------------------------------------------------
   initial begin
      int k;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: extreme corners, a point exactly on the radius and one
      // just outside, then a pass end that shrinks the radius.
      add_point(-8388608, -8388608, -8388608, 0, 0, 1);
      add_point(8388607, 8388607, 8388607, 1048575, 0, 0);
      add_point(-8388608 + 1024, -8388608, -8388608, 2, 0, 0);
      add_point(-8388608 + 1025, -8388608, -8388608, 3, 0, 0);
      add_point(0, 0, 0, 4, 0, 0);
      add_point(-600, -600, -600, 5, 0, 0);
      add_point(-591, -591, -591, 6, 1, 0);
      add_point(591, 591, 591, 7, 0, 0);
      settle();

      // Zero radius: only a duplicate is rejected; target reached, then restart.
      apply_settings(0, 3, 2, 0);
      add_point(5, 5, 5, 8, 0, 1);
      add_point(5, 5, 5, 9, 0, 0);
      add_point(5, 5, 6, 10, 1, 0);
      add_point(-1, -1, -1, 11, 0, 0);
      add_point(100, 100, 100, 12, 1, 0);
      add_point(100, 100, 100, 13, 0, 1);
      settle();

      // Widest radius, pass limit of zero ends the run at the first pass end.
      apply_settings(23'h7F_FFFF, 1024, 0, 16'hFFFF);
      add_point(0, 0, 0, 14, 0, 1);
      add_point(8388607, 8388607, 8388607, 15, 0, 0);
      add_point(-8388608, 0, 0, 16, 0, 0);
      add_point(1, 1, 1, 17, 1, 0);
      add_point(2, -2, 2, 18, 0, 0);
      settle();

      // Near-unity shrink moves the boundary by one unit.
      apply_settings(1000, 1024, 255, 16'hFFFF);
      add_point(0, 0, 0, 19, 0, 1);
      add_point(1000, 0, 0, 20, 1, 0);
      add_point(1000, 0, 0, 21, 0, 0);
      add_point(0, 999, 0, 22, 0, 0);
      settle();

      // Target of zero is done before the first point.
      apply_settings(1000, 0, 1, 58982);
      add_point(3, 3, 3, 23, 0, 1);
      add_point(3, 3, 3, 24, 1, 0);
      settle();

      // Single-pass limit, then nothing more is taken.
      apply_settings(1000, 1024, 1, 58982);
      add_point(0, 0, 0, 25, 0, 1);
      add_point(5000, 0, 0, 26, 1, 0);
      add_point(-5000, 0, 0, 27, 0, 0);
      settle();

      // Target above the store depth: distinct points keep being taken.
      apply_settings(0, 2047, 255, 16'hFFFF);
      for (k = 0; k < 6; k++)
         add_point(k * 8 - 4000, $urandom, $urandom, 28 + k, 0, k == 0);
      settle();

      while (random_items < 530)
         throw_random_cloud();

      settle();
      $display("Summary: %0d points judged over %0d register settings, %0d became samples",
               results_checked, settings_used, samples_taken);
      $display("Summary: directed corners, a target above the store depth, and %0d points %s",
               random_items, "from random clouds");
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
